### rtl/hrp_pkg.sv
// shared types, codes and character helpers for the http request header parser
`default_nettype none
package hrp_pkg;

  localparam int TOKEN_BUFFER_SIZE_DEF = 128;

  // parser states
  typedef enum logic [3:0] {
    ST_START      = 4'd0,
    ST_URI        = 4'd1,
    ST_VERSION    = 4'd2,
    ST_LINE_END   = 4'd3,
    ST_HEAD       = 4'd4,
    ST_HEAD_CR    = 4'd5,
    ST_HEAD_LF    = 4'd6,
    ST_EMPTY_LINE = 4'd7,
    ST_DONE       = 4'd8,
    ST_E400       = 4'd9,
    ST_E404       = 4'd10,
    ST_E414       = 4'd11,
    ST_E500       = 4'd12,
    ST_E501       = 4'd13,
    ST_E505       = 4'd14
  } parse_state_t;

  // parse status codes
  localparam logic [2:0] STATUS_PARSING     = 3'd0;
  localparam logic [2:0] STATUS_DONE        = 3'd1;
  localparam logic [2:0] STATUS_BAD_REQUEST = 3'd2;
  localparam logic [2:0] STATUS_NOT_FOUND   = 3'd3;
  localparam logic [2:0] STATUS_URI_LONG    = 3'd4;
  localparam logic [2:0] STATUS_INTERNAL    = 3'd5;
  localparam logic [2:0] STATUS_NOT_IMPL    = 3'd6;
  localparam logic [2:0] STATUS_VERSION     = 3'd7;

  // method codes
  localparam logic [1:0] METHOD_NONE = 2'd0;
  localparam logic [1:0] METHOD_GET  = 2'd1;
  localparam logic [1:0] METHOD_HEAD = 2'd2;

  // request kinds
  localparam logic KIND_BYTE     = 1'b0;
  localparam logic KIND_NEW_CONN = 1'b1;

  // characters
  localparam logic [7:0] CH_SP = 8'h20;
  localparam logic [7:0] CH_QM = 8'h3F;
  localparam logic [7:0] CH_CR = 8'h0D;
  localparam logic [7:0] CH_LF = 8'h0A;

  localparam int GET_LEN  = 3;
  localparam int HEAD_LEN = 4;
  localparam int VER_LEN  = 7;

  // per-connection flags
  typedef struct packed {
    logic       get_ok;
    logic       head_ok;
    logic       ver_ok;
    logic       query_seen;
    logic [1:0] method;
  } flags_t;

  localparam flags_t FLAGS_RESET = '{get_ok: 1'b1, head_ok: 1'b1, ver_ok: 1'b1,
                                     query_seen: 1'b0, method: METHOD_NONE};

  // one result
  typedef struct packed {
    logic [2:0] parse_status;
    logic [1:0] method_code;
    logic       path_byte_valid;
    logic       header_byte_valid;
    logic       header_chunk_end;
    logic       header_chunk_complete;
  } result_t;

  function automatic logic [7:0] get_char(input logic [1:0] idx);
    logic [7:0] c;
    unique case (idx)
      2'd0:    c = 8'h47;
      2'd1:    c = 8'h45;
      2'd2:    c = 8'h54;
      default: c = 8'h00;
    endcase
    return c;
  endfunction

  function automatic logic [7:0] head_char(input logic [1:0] idx);
    logic [7:0] c;
    unique case (idx)
      2'd0:    c = 8'h48;
      2'd1:    c = 8'h45;
      2'd2:    c = 8'h41;
      default: c = 8'h44;
    endcase
    return c;
  endfunction

  function automatic logic [7:0] ver_char(input logic [2:0] idx);
    logic [7:0] c;
    unique case (idx)
      3'd0:    c = 8'h48;
      3'd1:    c = 8'h54;
      3'd2:    c = 8'h54;
      3'd3:    c = 8'h50;
      3'd4:    c = 8'h2F;
      3'd5:    c = 8'h31;
      3'd6:    c = 8'h2E;
      default: c = 8'h00;
    endcase
    return c;
  endfunction

  function automatic logic [2:0] status_of(input parse_state_t s);
    logic [2:0] r;
    unique case (s)
      ST_DONE: r = STATUS_DONE;
      ST_E400: r = STATUS_BAD_REQUEST;
      ST_E404: r = STATUS_NOT_FOUND;
      ST_E414: r = STATUS_URI_LONG;
      ST_E500: r = STATUS_INTERNAL;
      ST_E501: r = STATUS_NOT_IMPL;
      ST_E505: r = STATUS_VERSION;
      default: r = STATUS_PARSING;
    endcase
    return r;
  endfunction

endpackage
`default_nettype wire

### rtl/hrp_req_if.sv
// request channel carrying one received byte or a new-connection mark
`default_nettype none
interface hrp_req_if;
  logic       valid;
  logic       ready;
  logic       kind;
  logic [7:0] rx_byte;
  logic       resource_found;
  logic       header_accept;

  modport source (output valid, kind, rx_byte, resource_found, header_accept,
                  input ready);
  modport sink   (input valid, kind, rx_byte, resource_found, header_accept,
                  output ready);
endinterface
`default_nettype wire

### rtl/hrp_res_if.sv
// result channel carrying parse status and per-byte flags
`default_nettype none
interface hrp_res_if;
  logic       valid;
  logic       ready;
  logic [2:0] parse_status;
  logic [1:0] method_code;
  logic       path_byte_valid;
  logic       header_byte_valid;
  logic       header_chunk_end;
  logic       header_chunk_complete;

  modport source (output valid, parse_status, method_code, path_byte_valid,
                  header_byte_valid, header_chunk_end, header_chunk_complete,
                  input ready);
  modport sink   (input valid, parse_status, method_code, path_byte_valid,
                  header_byte_valid, header_chunk_end, header_chunk_complete,
                  output ready);
endinterface
`default_nettype wire

### rtl/http_request_header_parser.sv
// top level of the http/1.x request line and header parser
//
// usage:
//   req channel (sink): one request per received byte (kind = 0) or a
//   new-connection mark (kind = 1) that returns the parser to its start
//   state; resource_found and header_accept are the external lookup and
//   header verdicts, sampled only at the byte where they are needed
//   res channel (source): exactly one result per request, in order, with
//   the parse status after that byte, the method and the per-byte flags
// path: an accepted request lands in the input register, is parsed
//   combinationally and moves into the result register once that register
//   can take it; res.valid rises as the result is loaded
// throughput: one request per cycle while res is not stalled, set by the
//   combinational parse step between the input register and the result
//   register; parser state updates as the request moves into that register
// reset: rst (synchronous, active high) empties both registers and puts
//   the parser at request start with no method and clean prefix flags
// stall: while res.ready is low the result holds; the input register
//   takes one more request if it is empty, then req.ready drops until res drains
`default_nettype none
module http_request_header_parser
  import hrp_pkg::*;
#(
  parameter int TOKEN_BUFFER_SIZE = TOKEN_BUFFER_SIZE_DEF
) (
  input wire logic clk,
  input wire logic rst,
  hrp_req_if.sink   req,
  hrp_res_if.source res
);

  // counter can hold the buffer size itself for the overflow compare
  localparam int CW = $clog2(TOKEN_BUFFER_SIZE + 1);

  // input register
  logic       in_valid;
  logic       in_kind;
  logic [7:0] in_byte;
  logic       in_found;
  logic       in_accept;

  // parser state
  parse_state_t  state;
  parse_state_t  state_next;
  logic [CW-1:0] count;
  logic [CW-1:0] count_next;
  flags_t        flags;
  flags_t        flags_next;

  result_t result;
  logic    can_load;
  logic    advance;

  // the held request moves on whenever the result register can take it
  assign advance   = in_valid && can_load;
  assign req.ready = !in_valid || advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (req.ready) begin
      in_valid <= req.valid;
    end
  end

  // payload needs no reset
  always_ff @(posedge clk) begin
    if (req.valid && req.ready) begin
      in_kind   <= req.kind;
      in_byte   <= req.rx_byte;
      in_found  <= req.resource_found;
      in_accept <= req.header_accept;
    end
  end

  hrp_step #(
    .TOKEN_BUFFER_SIZE (TOKEN_BUFFER_SIZE),
    .CW                (CW)
  ) u_step (
    .kind           (in_kind),
    .rx_byte        (in_byte),
    .resource_found (in_found),
    .header_accept  (in_accept),
    .state          (state),
    .count          (count),
    .flags          (flags),
    .state_next     (state_next),
    .count_next     (count_next),
    .flags_next     (flags_next),
    .result         (result)
  );

  // parser state commits only when its result is loaded
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_START;
      count <= '0;
      flags <= FLAGS_RESET;
    end else if (advance) begin
      state <= state_next;
      count <= count_next;
      flags <= flags_next;
    end
  end

  hrp_out_stage u_out (
    .clk       (clk),
    .rst       (rst),
    .load      (in_valid),
    .load_data (result),
    .can_load  (can_load),
    .res       (res)
  );

endmodule
`default_nettype wire

### rtl/hrp_step.sv
// combinational next-state and result logic for one request
`default_nettype none
module hrp_step
  import hrp_pkg::*;
#(
  parameter int TOKEN_BUFFER_SIZE = TOKEN_BUFFER_SIZE_DEF,
  parameter int CW = $clog2(TOKEN_BUFFER_SIZE + 1)
) (
  input  wire logic          kind,
  input  wire logic [7:0]    rx_byte,
  input  wire logic          resource_found,
  input  wire logic          header_accept,
  input  wire parse_state_t  state,
  input  wire logic [CW-1:0] count,
  input  wire flags_t        flags,
  output parse_state_t       state_next,
  output logic [CW-1:0]      count_next,
  output flags_t             flags_next,
  output result_t            result
);

  localparam logic [CW-1:0] FULL      = CW'(TOKEN_BUFFER_SIZE);
  localparam logic [CW-1:0] HEAD_FULL = CW'(TOKEN_BUFFER_SIZE - 1);

  logic [CW-1:0] count_inc;
  logic          path_v;
  logic          head_v;
  logic          chunk_end;
  logic          chunk_full;

  assign count_inc = count + CW'(1);

  always_comb begin
    state_next = state;
    count_next = count;
    flags_next = flags;
    path_v     = 1'b0;
    head_v     = 1'b0;
    chunk_end  = 1'b0;
    chunk_full = 1'b0;
    if (kind == KIND_NEW_CONN) begin
      state_next = ST_START;
      count_next = '0;
      flags_next = FLAGS_RESET;
    end else begin
      unique case (state)
        ST_START: begin
          if (rx_byte == CH_SP) begin
            if (flags.get_ok && count == CW'(GET_LEN)) begin
              flags_next.method = METHOD_GET;
            end else if (flags.head_ok && count == CW'(HEAD_LEN)) begin
              flags_next.method = METHOD_HEAD;
            end else begin
              flags_next.method = METHOD_NONE;
            end
            count_next = '0;
            state_next = (flags_next.method == METHOD_NONE) ? ST_E501 : ST_URI;
          end else begin
            if (count >= CW'(GET_LEN) || get_char(count[1:0]) != rx_byte) begin
              flags_next.get_ok = 1'b0;
            end
            if (count >= CW'(HEAD_LEN) || head_char(count[1:0]) != rx_byte) begin
              flags_next.head_ok = 1'b0;
            end
            count_next = count_inc;
            if (count_inc >= FULL) state_next = ST_E500;
          end
        end
        ST_URI: begin
          if (rx_byte == CH_SP) begin
            count_next = '0;
            state_next = resource_found ? ST_VERSION : ST_E404;
          end else begin
            if (rx_byte == CH_QM) flags_next.query_seen = 1'b1;
            if (count_inc >= FULL) begin
              count_next = '0;
              state_next = ST_E414;
            end else begin
              count_next = count_inc;
              path_v     = !flags_next.query_seen;
            end
          end
        end
        ST_VERSION: begin
          if (rx_byte == CH_CR) begin
            count_next = '0;
            state_next = (flags.ver_ok && count >= CW'(VER_LEN)) ? ST_LINE_END : ST_E505;
          end else begin
            if (count < CW'(VER_LEN) && ver_char(count[2:0]) != rx_byte) begin
              flags_next.ver_ok = 1'b0;
            end
            count_next = count_inc;
            if (count_inc >= FULL) state_next = ST_E500;
          end
        end
        ST_LINE_END: begin
          state_next = (rx_byte == CH_LF) ? ST_HEAD : ST_E400;
        end
        ST_HEAD: begin
          if (rx_byte == CH_CR) begin
            chunk_end  = 1'b1;
            chunk_full = 1'b1;
            count_next = '0;
            state_next = header_accept ? ST_HEAD_CR : ST_E500;
          end else begin
            head_v     = 1'b1;
            count_next = count_inc;
            if (count_inc >= HEAD_FULL) begin
              chunk_end  = 1'b1;
              count_next = '0;
              state_next = header_accept ? ST_HEAD : ST_E500;
            end
          end
        end
        ST_HEAD_CR: begin
          state_next = (rx_byte == CH_LF) ? ST_HEAD_LF : ST_E400;
        end
        ST_HEAD_LF: begin
          if (rx_byte == CH_CR) begin
            state_next = ST_EMPTY_LINE;
          end else begin
            head_v     = 1'b1;
            count_next = CW'(1);
            state_next = ST_HEAD;
          end
        end
        ST_EMPTY_LINE: begin
          state_next = (rx_byte == CH_LF) ? ST_DONE : ST_E400;
        end
        default: begin
          // done and error states absorb bytes
        end
      endcase
    end
  end

  always_comb begin
    result.parse_status          = status_of(state_next);
    result.method_code           = flags_next.method;
    result.path_byte_valid       = path_v;
    result.header_byte_valid     = head_v;
    result.header_chunk_end      = chunk_end;
    result.header_chunk_complete = chunk_full;
  end

endmodule
`default_nettype wire

### rtl/hrp_out_stage.sv
// result register with valid/ready handshake toward the receiver
`default_nettype none
module hrp_out_stage
  import hrp_pkg::*;
(
  input  wire logic    clk,
  input  wire logic    rst,
  input  wire logic    load,
  input  wire result_t load_data,
  output logic         can_load,
  hrp_res_if.source    res
);

  logic    valid;
  result_t data;

  assign can_load = !valid || res.ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (can_load) begin
      valid <= load;
    end
  end

  always_ff @(posedge clk) begin
    if (load && can_load) begin
      data <= load_data;
    end
  end

  assign res.valid                 = valid;
  assign res.parse_status          = data.parse_status;
  assign res.method_code           = data.method_code;
  assign res.path_byte_valid       = data.path_byte_valid;
  assign res.header_byte_valid     = data.header_byte_valid;
  assign res.header_chunk_end      = data.header_chunk_end;
  assign res.header_chunk_complete = data.header_chunk_complete;

endmodule
`default_nettype wire

### rtl/hrp_checker.sv
// port-level checks for the http request header parser, bound to the top level
`default_nettype none
module hrp_checker
  import hrp_pkg::*;
(
  input wire logic       clk,
  input wire logic       rst,
  input wire logic       res_valid,
  input wire logic       res_ready,
  input wire logic [2:0] parse_status,
  input wire logic [1:0] method_code,
  input wire logic       path_byte_valid,
  input wire logic       header_byte_valid,
  input wire logic       header_chunk_end,
  input wire logic       header_chunk_complete
);

  // a complete chunk is always a chunk end
  a_chunk_complete: assert property (@(posedge clk) disable iff (rst)
    res_valid && header_chunk_complete |-> header_chunk_end)
    else $error("chunk complete without chunk end");

  // a byte is never both path and header content
  a_flags_exclusive: assert property (@(posedge clk) disable iff (rst)
    res_valid |-> !(path_byte_valid && header_byte_valid))
    else $error("path and header flags together");

  // path bytes only while parsing with a known method
  a_path_context: assert property (@(posedge clk) disable iff (rst)
    res_valid && path_byte_valid |->
      parse_status == STATUS_PARSING &&
      (method_code == METHOD_GET || method_code == METHOD_HEAD))
    else $error("path byte outside a valid uri");

  // a stalled result holds
  a_stall_hold: assert property (@(posedge clk) disable iff (rst)
    res_valid && !res_ready |=> res_valid && $stable(parse_status) &&
      $stable(method_code) && $stable(path_byte_valid) &&
      $stable(header_byte_valid) && $stable(header_chunk_end))
    else $error("result changed while stalled");

endmodule

bind http_request_header_parser hrp_checker u_checker (
  .clk                   (clk),
  .rst                   (rst),
  .res_valid             (res.valid),
  .res_ready             (res.ready),
  .parse_status          (res.parse_status),
  .method_code           (res.method_code),
  .path_byte_valid       (res.path_byte_valid),
  .header_byte_valid     (res.header_byte_valid),
  .header_chunk_end      (res.header_chunk_end),
  .header_chunk_complete (res.header_chunk_complete)
);
`default_nettype wire

### tb/sv/http_request_header_parser_tb.sv
// self-checking testbench for the http request header parser: directed and random byte streams
`timescale 1ns / 100ps
module http_request_header_parser_tb;
  import hrp_pkg::*;

  localparam int BUF_SIZE     = TOKEN_BUFFER_SIZE_DEF;
  localparam int ITEM_TARGET  = 1050;
  localparam int CYCLE_LIMIT  = 500000;
  localparam int DRAIN_CYCLES = 12;

  // words the parser matches against, first character in the top byte
  localparam logic [8*GET_LEN-1:0]  GET_WORD  = "GET";
  localparam logic [8*HEAD_LEN-1:0] HEAD_WORD = "HEAD";
  localparam logic [8*VER_LEN-1:0]  VER_WORD  = "HTTP/1.";

  logic clk;
  logic rst;

  hrp_req_if req_bus ();
  hrp_res_if res_bus ();

  http_request_header_parser #(
    .TOKEN_BUFFER_SIZE(BUF_SIZE)
  ) uut (
    .clk(clk),
    .rst(rst),
    .req(req_bus),
    .res(res_bus)
  );

  // parser state as predicted from the accepted requests
  parse_state_t req_state;
  int           tok_len;
  bit           get_ok;
  bit           head_ok;
  bit           ver_ok;
  bit           in_query;
  logic [1:0]   method_seen;

  // predicted results, oldest first
  result_t status_queue[$];

  int  fail_count    = 0;
  int  cycle_count   = 0;
  int  sent_items    = 0;
  int  spill         = 0;
  bit  steady_flow   = 1'b0;
  int  found_pct     = 88;
  int  accept_pct    = 96;

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // ---------------------------------------------------------------------------
  // parser prediction
  // ---------------------------------------------------------------------------

  function automatic void reset_parser();
    req_state   = ST_START;
    tok_len     = 0;
    get_ok      = 1'b1;
    head_ok     = 1'b1;
    ver_ok      = 1'b1;
    in_query    = 1'b0;
    method_seen = METHOD_NONE;
  endfunction

  // status code reported for a parser state
  function automatic logic [2:0] state_code(input parse_state_t s);
    case (s)
      ST_DONE: return STATUS_DONE;
      ST_E400: return STATUS_BAD_REQUEST;
      ST_E404: return STATUS_NOT_FOUND;
      ST_E414: return STATUS_URI_LONG;
      ST_E500: return STATUS_INTERNAL;
      ST_E501: return STATUS_NOT_IMPL;
      ST_E505: return STATUS_VERSION;
      default: return STATUS_PARSING;
    endcase
  endfunction

  // done and every error state swallow bytes until a new connection
  function automatic bit parser_absorbing();
    return req_state >= ST_DONE;
  endfunction

  // one request moves the parser one step and yields exactly one result
  function automatic result_t parse_byte(input logic kind, input logic [7:0] b,
                                         input logic found, input logic accept);
    result_t r;
    r = '0;
    if (kind == KIND_NEW_CONN) begin
      reset_parser();
    end else begin
      case (req_state)
        ST_START: begin
          if (b == CH_SP) begin
            // method must be exactly GET or HEAD, empty counts as unknown
            if (get_ok && tok_len == GET_LEN) method_seen = METHOD_GET;
            else if (head_ok && tok_len == HEAD_LEN) method_seen = METHOD_HEAD;
            else method_seen = METHOD_NONE;
            tok_len   = 0;
            req_state = (method_seen == METHOD_NONE) ? ST_E501 : ST_URI;
          end else begin
            if (tok_len >= GET_LEN) get_ok = 1'b0;
            else if (GET_WORD[8*(GET_LEN-1-tok_len) +: 8] != b) get_ok = 1'b0;
            if (tok_len >= HEAD_LEN) head_ok = 1'b0;
            else if (HEAD_WORD[8*(HEAD_LEN-1-tok_len) +: 8] != b) head_ok = 1'b0;
            tok_len++;
            if (tok_len >= BUF_SIZE) req_state = ST_E500;
          end
        end
        ST_URI: begin
          if (b == CH_SP) begin
            // lookup verdict is taken at the space closing the uri
            tok_len   = 0;
            req_state = found ? ST_VERSION : ST_E404;
          end else begin
            if (b == CH_QM) in_query = 1'b1;
            tok_len++;
            if (tok_len >= BUF_SIZE) begin
              // overflowing byte is not flagged as path
              tok_len   = 0;
              req_state = ST_E414;
            end else begin
              r.path_byte_valid = !in_query;
            end
          end
        end
        ST_VERSION: begin
          if (b == CH_CR) begin
            req_state = (ver_ok && tok_len >= VER_LEN) ? ST_LINE_END : ST_E505;
            tok_len   = 0;
          end else begin
            if (tok_len < VER_LEN) begin
              if (VER_WORD[8*(VER_LEN-1-tok_len) +: 8] != b) ver_ok = 1'b0;
            end
            tok_len++;
            if (tok_len >= BUF_SIZE) req_state = ST_E500;
          end
        end
        ST_LINE_END: req_state = (b == CH_LF) ? ST_HEAD : ST_E400;
        ST_HEAD: begin
          if (b == CH_CR) begin
            // complete chunk ends at cr
            r.header_chunk_end      = 1'b1;
            r.header_chunk_complete = 1'b1;
            tok_len   = 0;
            req_state = accept ? ST_HEAD_CR : ST_E500;
          end else begin
            r.header_byte_valid = 1'b1;
            tok_len++;
            if (tok_len >= BUF_SIZE - 1) begin
              // buffer full: partial chunk, line goes on
              r.header_chunk_end = 1'b1;
              tok_len   = 0;
              req_state = accept ? ST_HEAD : ST_E500;
            end
          end
        end
        ST_HEAD_CR: req_state = (b == CH_LF) ? ST_HEAD_LF : ST_E400;
        ST_HEAD_LF: begin
          if (b == CH_CR) begin
            req_state = ST_EMPTY_LINE;
          end else begin
            r.header_byte_valid = 1'b1;
            tok_len   = 1;
            req_state = ST_HEAD;
          end
        end
        ST_EMPTY_LINE: req_state = (b == CH_LF) ? ST_DONE : ST_E400;
        default: ;
      endcase
    end
    r.parse_status = state_code(req_state);
    r.method_code  = method_seen;
    return r;
  endfunction

  // ---------------------------------------------------------------------------
  // idling
  // ---------------------------------------------------------------------------

  // mostly back to back, some short gaps, a few long ones
  function automatic int pick_gap();
    int r;
    r = $urandom_range(99);
    if (steady_flow || r < 55) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(4, 24);
  endfunction

  // result side: ready in random runs with random stalls between them
  initial begin
    res_bus.ready <= 1'b0;
    @(posedge clk);
    forever begin
      res_bus.ready <= 1'b1;
      repeat ($urandom_range(1, 8)) @(posedge clk);
      if (!steady_flow) begin
        res_bus.ready <= 1'b0;
        repeat (pick_gap() + 1) @(posedge clk);
      end
    end
  end

  // ---------------------------------------------------------------------------
  // request driving
  // ---------------------------------------------------------------------------

  // valid stays high between back-to-back requests, prediction at acceptance
  task automatic send_request(input logic kind, input logic [7:0] b,
                              input logic found, input logic accept);
    int gap;
    gap = pick_gap();
    if (gap > 0) begin
      req_bus.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    req_bus.valid          <= 1'b1;
    req_bus.kind           <= kind;
    req_bus.rx_byte        <= b;
    req_bus.resource_found <= found;
    req_bus.header_accept  <= accept;
    do @(posedge clk); while (!req_bus.ready);
    status_queue.push_back(parse_byte(kind, b, found, accept));
    sent_items++;
  endtask

  task automatic new_connection();
    spill = $urandom_range(0, 3);
    send_request(KIND_NEW_CONN, 8'($urandom_range(255)), 1'($urandom_range(1)),
                 1'($urandom_range(1)));
  endtask

  // once the parser absorbs, only a few trailing bytes are still sent
  task automatic send_byte(input logic [7:0] b);
    if (parser_absorbing()) begin
      if (spill == 0) return;
      spill--;
    end
    send_request(KIND_BYTE, b, $urandom_range(99) < found_pct,
                 $urandom_range(99) < accept_pct);
  endtask

  task automatic send_text(input string s);
    for (int i = 0; i < s.len(); i++) send_byte(s[i]);
  endtask

  task automatic send_crlf();
    send_byte(CH_CR);
    send_byte(CH_LF);
  endtask

  task automatic send_repeat(input int n, input logic [7:0] b);
    repeat (n) send_byte(b);
  endtask

  function automatic logic [7:0] byte_except(input logic [7:0] stop);
    logic [7:0] b;
    do b = 8'($urandom_range(255)); while (b == stop);
    return b;
  endfunction

  task automatic send_noise_token(input int n, input logic [7:0] stop);
    repeat (n) send_byte(byte_except(stop));
  endtask

  // token length: mostly short, now and then around the buffer size
  function automatic int pick_len(input int short_max);
    if ($urandom_range(99) < 97) return $urandom_range(0, short_max);
    return $urandom_range(BUF_SIZE - 3, 2 * BUF_SIZE + 2);
  endfunction

  // ---------------------------------------------------------------------------
  // result checking
  // ---------------------------------------------------------------------------

  function automatic void check_field(input string name, input logic [7:0] want,
                                      input logic [7:0] got);
    if (got !== want) begin
      $error("%s: expected %0d, actual %0d", name, want, got);
      fail_count++;
    end
  endfunction

  always @(posedge clk) begin
    result_t want;
    if (!rst && res_bus.valid && res_bus.ready) begin
      if (status_queue.size() == 0) begin
        $error("result with no request waiting: status %0d", res_bus.parse_status);
        fail_count++;
      end else begin
        want = status_queue.pop_front();
        check_field("parse_status", want.parse_status, res_bus.parse_status);
        check_field("method_code", want.method_code, res_bus.method_code);
        check_field("path_byte_valid", want.path_byte_valid, res_bus.path_byte_valid);
        check_field("header_byte_valid", want.header_byte_valid,
                    res_bus.header_byte_valid);
        check_field("header_chunk_end", want.header_chunk_end, res_bus.header_chunk_end);
        check_field("header_chunk_complete", want.header_chunk_complete,
                    res_bus.header_chunk_complete);
      end
    end
  end

  // hard stop for a hung handshake
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("http_request_header_parser_tb failed");
      $finish;
    end
  end

  // ---------------------------------------------------------------------------
  // directed tests
  // ---------------------------------------------------------------------------

  // full get with a query, extreme byte values in the path, one header line
  task automatic test_get_request();
    new_connection();
    send_text("GET /");
    send_byte(8'h00);
    send_byte(8'hFF);
    send_text("?q HTTP/1.1");
    send_crlf();
    send_text("Host: x");
    send_crlf();
    send_crlf();
    send_text("zz");
  endtask

  // head with a failed lookup, then an empty uri that is found
  task automatic test_head_lookup();
    new_connection();
    found_pct = 0;
    send_text("HEAD /x ");
    found_pct = 100;
    send_text("HTTP");
    new_connection();
    send_text("HEAD  HTTP/1.0");
    send_crlf();
    send_crlf();
  endtask

  // empty, unknown, overlong and truncated methods
  task automatic test_method_errors();
    new_connection();
    send_byte(CH_SP);
    new_connection();
    send_text("POST /");
    new_connection();
    send_text("GETS /");
    new_connection();
    send_text("HEA /");
  endtask

  // short version and wrong major version
  task automatic test_version_errors();
    new_connection();
    send_text("GET / HTTP/1");
    send_byte(CH_CR);
    new_connection();
    send_text("HEAD / HTTP/2.0");
    send_byte(CH_CR);
  endtask

  // cr not followed by lf on the request line, on a header line and on an empty first header line
  task automatic test_line_end_errors();
    new_connection();
    send_text("GET / HTTP/1.1");
    send_byte(CH_CR);
    send_text("x");
    new_connection();
    send_text("GET / HTTP/1.1");
    send_crlf();
    send_text("a");
    send_byte(CH_CR);
    send_byte(CH_CR);
    new_connection();
    send_text("GET / HTTP/1.1");
    send_crlf();
    send_byte(CH_CR);
    send_text("c");
  endtask

  // header chunk turned down at cr
  task automatic test_chunk_rejected();
    new_connection();
    send_text("GET / HTTP/1.1");
    send_crlf();
    send_text("a");
    accept_pct = 0;
    send_byte(CH_CR);
    accept_pct = 100;
  endtask

  // every token at the buffer size, plus a long header split into partial chunks
  task automatic test_buffer_limits();
    new_connection();
    send_repeat(BUF_SIZE, "G");
    new_connection();
    send_text("GET ");
    send_repeat(BUF_SIZE, "a");
    new_connection();
    send_text("GET / ");
    send_repeat(BUF_SIZE, "V");
    new_connection();
    send_text("GET / HTTP/1.1");
    send_crlf();
    send_repeat(BUF_SIZE + 8, "h");
    send_crlf();
    send_crlf();
    // partial chunk turned down
    new_connection();
    send_text("GET / HTTP/1.1");
    send_crlf();
    send_repeat(BUF_SIZE - 2, "h");
    accept_pct = 0;
    send_byte("h");
    accept_pct = 100;
  endtask

  // ---------------------------------------------------------------------------
  // random requests
  // ---------------------------------------------------------------------------

  task automatic random_method();
    int pick;
    pick = $urandom_range(99);
    if (pick < 45) send_text("GET");
    else if (pick < 85) send_text("HEAD");
    else if (pick < 92) begin
      case ($urandom_range(5))
        0: send_text("GE");
        1: send_text("GETT");
        2: send_text("HEA");
        3: send_text("HEADS");
        4: send_text("get");
        default: send_text("POST");
      endcase
    end else send_noise_token(pick_len(6), CH_SP);
  endtask

  task automatic random_uri();
    int n;
    n = pick_len(8);
    repeat (n) send_byte(($urandom_range(9) == 0) ? CH_QM : byte_except(CH_SP));
  endtask

  task automatic random_version();
    int pick;
    pick = $urandom_range(99);
    if (pick < 85) begin
      send_text("HTTP/1.");
      send_noise_token($urandom_range(0, 3), CH_CR);
    end else if (pick < 90) begin
      send_text("HTTP/1");
    end else if (pick < 96) begin
      send_noise_token($urandom_range(0, 10), CH_CR);
    end else begin
      send_text("HTTP/1.");
      send_noise_token($urandom_range(BUF_SIZE - 9, BUF_SIZE), CH_CR);
    end
  endtask

  // lf, or now and then a stray byte that breaks the line ending
  task automatic random_lf();
    send_byte(($urandom_range(19) == 0) ? 8'($urandom_range(255)) : CH_LF);
  endtask

  task automatic random_request();
    new_connection();
    random_method();
    send_byte(CH_SP);
    random_uri();
    send_byte(CH_SP);
    random_version();
    send_byte(CH_CR);
    random_lf();
    repeat ($urandom_range(0, 3)) begin
      send_noise_token(pick_len(10), CH_CR);
      send_byte(CH_CR);
      random_lf();
    end
    send_byte(CH_CR);
    random_lf();
    send_noise_token($urandom_range(0, 2), 8'h00);
  endtask

  // unstructured bytes, rich in delimiters
  task automatic noise_sequence();
    new_connection();
    repeat ($urandom_range(1, 12)) begin
      case ($urandom_range(3))
        0: send_byte(CH_SP);
        1: send_byte(CH_CR);
        2: send_byte(CH_LF);
        default: send_byte(8'($urandom_range(255)));
      endcase
    end
  endtask

  // random requests fill up the run to the item target
  task automatic test_random_requests();
    int n_req;
    n_req      = 0;
    found_pct  = 88;
    accept_pct = 96;
    while (sent_items < ITEM_TARGET) begin
      // some stretches run with no idling on either side
      if (n_req % 8 == 0) steady_flow = ($urandom_range(3) == 0);
      if ($urandom_range(99) < 8) noise_sequence();
      else random_request();
      n_req++;
    end
    steady_flow = 1'b0;
  endtask

  // ---------------------------------------------------------------------------
  // run
  // ---------------------------------------------------------------------------

  initial begin
    req_bus.valid          <= 1'b0;
    req_bus.kind           <= KIND_BYTE;
    req_bus.rx_byte        <= 8'h00;
    req_bus.resource_found <= 1'b0;
    req_bus.header_accept  <= 1'b0;
    rst                    <= 1'b1;
    reset_parser();
    repeat (2) @(posedge clk);
    rst <= 1'b0;

    found_pct  = 100;
    accept_pct = 100;
    test_get_request();
    test_head_lookup();
    test_method_errors();
    test_version_errors();
    test_line_end_errors();
    test_chunk_rejected();
    test_buffer_limits();
    test_random_requests();

    req_bus.valid <= 1'b0;
    while (status_queue.size() != 0) @(posedge clk);
    // catch any result beyond the last expected one
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (fail_count == 0) begin
      $display("http_request_header_parser_tb passed");
    end else begin
      $display("http_request_header_parser_tb failed");
    end
    $finish;
  end

endmodule
